// File: rtl/stpbpdu_pkg.sv
// Package with the constants and types of the spanning-tree BPDU frame parser.
`timescale 1ns / 1ps

package stpbpdu_pkg;

  // Frame layout.
  localparam int MAC_BYTES       = 6;
  localparam int RAW_START       = 14;
  localparam int LLC_START       = 17;
  localparam int LLC_SKIP        = LLC_START - RAW_START;
  localparam int HDR_BYTES       = 4;
  localparam int BPDU_BODY_BYTES = 35;
  localparam int BODY_DEPTH      = BPDU_BODY_BYTES + LLC_SKIP;

  // Byte position counter and the lengths it is compared against.
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
  localparam logic [POS_W-1:0] POS_MAC_END   = POS_W'(MAC_BYTES);
  localparam logic [POS_W-1:0] POS_LT_HI     = 6'd12;
  localparam logic [POS_W-1:0] POS_LT_LO     = 6'd13;
  localparam logic [POS_W-1:0] POS_DSAP      = POS_W'(RAW_START);
  localparam logic [POS_W-1:0] POS_SSAP      = POS_W'(RAW_START + 1);
  localparam logic [POS_W-1:0] LEN_RAW_MIN   = POS_W'(RAW_START);
  localparam logic [POS_W-1:0] LEN_LLC_MIN   = POS_W'(LLC_START);
  localparam logic [POS_W-1:0] LEN_RAW_HDR   = POS_W'(RAW_START + HDR_BYTES);
  localparam logic [POS_W-1:0] LEN_LLC_HDR   = POS_W'(LLC_START + HDR_BYTES);
  localparam logic [POS_W-1:0] LEN_RAW_FULL  = POS_W'(RAW_START + BPDU_BODY_BYTES);
  localparam logic [POS_W-1:0] LEN_LLC_FULL  = POS_W'(LLC_START + BPDU_BODY_BYTES);

  // Largest length/type value that still means an 802.3 length field.
  localparam logic [15:0] MAX_LEN_FIELD = 16'h05DC;

  // BPDU type codes that carry a full body.
  localparam logic [7:0] KIND_CONFIG = 8'h00;
  localparam logic [7:0] KIND_RST    = 8'h02;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_GROUP_MAC = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_LLC_SAP   = 1'b1;
  localparam logic [47:0] GROUP_MAC_RESET = 48'h0180C2000000;
  localparam logic [7:0]  LLC_SAP_RESET   = 8'h42;

  // Channel widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 272;
  localparam int OUT_USER_W = 2;

  // Bit positions of the result fields in out_tdata.
  localparam int FLAGS_LSB  = 24;

  typedef logic [7:0] byte_t;

endpackage

// File: rtl/stp_bpdu_frame_parser.sv
// Top level of the spanning-tree BPDU frame parser.
`timescale 1ns / 1ps
//
// The parser takes an Ethernet frame one byte per transfer on the in_ channel,
// with in_tlast high on the final byte. For every frame it sends one summary
// transfer on the out_ channel: out_tuser tells whether the frame is a BPDU
// and whether the config/RST body was decoded, out_tdata holds the fields.
// The cfg_ port writes the group MAC and the LLC SAP value to match.
// Each byte lands in an input register, is folded into the frame state and,
// on the last byte, the summary is formed in one pass and caught in the output
// register. Throughput is one byte per cycle while no last byte waits for the
// output register, set by the single-byte datapath; the next frame can begin
// right behind the last byte of the previous one.
// When the receiver stalls, the result waits in the output register while
// bytes of the next frame keep flowing; only a second last byte is held in
// the input register until the output register is free.
// A synchronous reset empties both registers, restores the default group MAC
// 01:80:C2:00:00:00 and SAP 0x42, and clears the frame state but not the body bytes.
module stp_bpdu_frame_parser (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [stpbpdu_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] frame_byte
  input  logic                                   in_tlast,   // end_of_frame
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [7:0] protocol_byte, [15:8] proto_version, [23:16] bpdu_kind,
  // [31:24] flag_bits, [95:32] root_id, [127:96] path_cost,
  // [191:128] sender_id, [207:192] port_ident, [271:208] timer_words
  output logic [stpbpdu_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [stpbpdu_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] valid_bpdu, [1] full_fields
  // Configuration writes.
  input  logic                                   cfg_we,
  input  logic [stpbpdu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [stpbpdu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import stpbpdu_pkg::*;

  // Configuration registers.
  logic [47:0] group_mac_r;
  logic [7:0]  llc_sap_r;

  // Input register.
  logic        s1_valid_r;
  byte_t       s1_byte_r;
  logic        s1_eof_r;

  // Frame state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             mac_ok_r, mac_ok_nxt;
  logic [15:0]      lt_word_r, lt_word_nxt;
  logic             sap_ok_r, sap_ok_nxt;
  byte_t            body_r [BODY_DEPTH];
  byte_t            body_nxt [BODY_DEPTH];

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  // Handshake control.
  logic out_free;
  logic s1_advance;
  logic s1_done;
  logic in_xfer;

  assign out_free   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && (!s1_eof_r || out_free);
  assign s1_done    = s1_advance && s1_eof_r;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_xfer    = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_mac_r <= GROUP_MAC_RESET;
      llc_sap_r   <= LLC_SAP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IDX_GROUP_MAC: group_mac_r <= cfg_wdata[47:0];
        CFG_IDX_LLC_SAP:   llc_sap_r   <= cfg_wdata[7:0];
        default:           ;
      endcase
    end
  end

  // Input register takes a byte whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata[7:0];
      s1_eof_r  <= in_tlast;
    end
  end

  // Fold the current byte into the frame state.
  always_comb begin
    logic [47:0]      mac_shift;
    logic [POS_W-1:0] body_idx;
    logic             body_hit;
    mac_shift  = group_mac_r >> {3'(3'd5 - pos_r[2:0]), 3'b000};
    body_idx   = pos_r - LEN_RAW_MIN;
    body_hit   = (pos_r >= LEN_RAW_MIN) && (body_idx < POS_W'(BODY_DEPTH));

    mac_ok_nxt = mac_ok_r;
    if (pos_r < POS_MAC_END && s1_byte_r != mac_shift[7:0]) begin
      mac_ok_nxt = 1'b0;
    end

    lt_word_nxt = lt_word_r;
    if (pos_r == POS_LT_HI) begin
      lt_word_nxt[15:8] = s1_byte_r;
    end
    if (pos_r == POS_LT_LO) begin
      lt_word_nxt[7:0] = s1_byte_r;
    end

    sap_ok_nxt = sap_ok_r;
    if ((pos_r == POS_DSAP || pos_r == POS_SSAP) && s1_byte_r != llc_sap_r) begin
      sap_ok_nxt = 1'b0;
    end

    for (int i = 0; i < BODY_DEPTH; i++) begin
      body_nxt[i] = (body_hit && body_idx == POS_W'(i)) ? s1_byte_r : body_r[i];
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // Summary of the frame, formed on its last byte.
  always_comb begin
    logic  is_llc;
    logic  hdr_ok;
    logic  body_ok;
    byte_t win [BPDU_BODY_BYTES];
    logic [63:0] root_id;
    logic [31:0] path_cost;
    logic [63:0] sender_id;
    logic [15:0] port_ident;
    logic [63:0] timer_words;

    is_llc = (lt_word_nxt <= MAX_LEN_FIELD);

    // Frame checks up to and including the BPDU header.
    if (pos_nxt < LEN_RAW_MIN || !mac_ok_nxt) begin
      hdr_ok = 1'b0;
    end else if (is_llc) begin
      hdr_ok = sap_ok_nxt && (pos_nxt >= LEN_LLC_HDR);
    end else begin
      hdr_ok = (pos_nxt >= LEN_RAW_HDR);
    end

    // BPDU bytes start at byte 14 for raw frames and byte 17 after LLC.
    for (int j = 0; j < BPDU_BODY_BYTES; j++) begin
      win[j] = is_llc ? body_nxt[j + LLC_SKIP] : body_nxt[j];
    end

    body_ok = hdr_ok && (win[3] == KIND_CONFIG || win[3] == KIND_RST) &&
              (pos_nxt >= (is_llc ? LEN_LLC_FULL : LEN_RAW_FULL));

    // Big-endian words of the config/RST body.
    for (int k = 0; k < 8; k++) begin
      root_id[8*(7-k) +: 8]     = win[5 + k];
      sender_id[8*(7-k) +: 8]   = win[17 + k];
      timer_words[8*(7-k) +: 8] = win[27 + k];
    end
    for (int k = 0; k < 4; k++) begin
      path_cost[8*(3-k) +: 8] = win[13 + k];
    end
    port_ident = {win[25], win[26]};

    out_data_nxt = '0;
    if (hdr_ok) begin
      out_data_nxt[7:0]   = win[0];
      out_data_nxt[15:8]  = win[2];
      out_data_nxt[23:16] = win[3];
    end
    if (body_ok) begin
      out_data_nxt[31:24]   = win[4];
      out_data_nxt[95:32]   = root_id;
      out_data_nxt[127:96]  = path_cost;
      out_data_nxt[191:128] = sender_id;
      out_data_nxt[207:192] = port_ident;
      out_data_nxt[271:208] = timer_words;
    end
    out_user_nxt = {body_ok, hdr_ok};
  end

  // Frame state registers; the last byte starts a fresh frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      mac_ok_r  <= 1'b1;
      lt_word_r <= '0;
      sap_ok_r  <= 1'b1;
    end else if (s1_advance) begin
      if (s1_eof_r) begin
        pos_r     <= '0;
        mac_ok_r  <= 1'b1;
        lt_word_r <= '0;
        sap_ok_r  <= 1'b1;
      end else begin
        pos_r     <= pos_nxt;
        mac_ok_r  <= mac_ok_nxt;
        lt_word_r <= lt_word_nxt;
        sap_ok_r  <= sap_ok_nxt;
      end
    end
  end

  // Body bytes of the frame, held across the frame boundary.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      for (int i = 0; i < BODY_DEPTH; i++) begin
        body_r[i] <= body_nxt[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/stpbpdu_checker.sv
// Port-level checks for the spanning-tree BPDU frame parser, with its bind.
`timescale 1ns / 1ps

module stpbpdu_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [stpbpdu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [stpbpdu_pkg::OUT_USER_W-1:0] out_tuser
);

  import stpbpdu_pkg::*;

  // A result offered but not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // A decoded body only comes with an accepted BPDU.
  a_full_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("body decoded on a rejected frame");

  // A rejected frame carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected frame with nonzero fields");

  // A header-only BPDU carries zero body fields.
  a_header_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[OUT_DATA_W-1:FLAGS_LSB] == '0)
    else $error("body fields set without a decoded body");

endmodule

bind stp_bpdu_frame_parser stpbpdu_checker u_stpbpdu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
